@@ sv/bccg_pkg.sv @@
// Shared types and constants for the button click gesture classifier.
package bccg_pkg;

  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 10;
  localparam int PrescBits = 6;
  localparam int TimeBits = 10;
  localparam int CountBits = 3;
  localparam int GestureBits = 3;

  localparam logic [CfgIdxBits-1:0] CFG_SAMPLES_PER_UNIT = 3'd0;
  localparam logic [CfgIdxBits-1:0] CFG_SHORT_LIMIT = 3'd1;
  localparam logic [CfgIdxBits-1:0] CFG_CLICK_WINDOW_TIME = 3'd2;
  localparam logic [CfgIdxBits-1:0] CFG_LONG_LIMIT = 3'd3;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_HOLD = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_ARM      = 3'd1,
    MODE_HELD     = 3'd2,
    MODE_WINDOW   = 3'd3,
    MODE_WIN_ARM  = 3'd4,
    MODE_WIN_HELD = 3'd5
  } mode_t;

  typedef enum logic [GestureBits-1:0] {
    G_UNKNOWN = 3'd0,
    G_SINGLE  = 3'd1,
    G_DOUBLE  = 3'd2,
    G_TRIPLE  = 3'd3,
    G_LONG    = 3'd4
  } gesture_t;

  typedef struct packed {
    logic                 emit;
    gesture_t             gesture;
    logic [CountBits-1:0] click_count;
  } result_t;

  typedef struct packed {
    logic [PrescBits-1:0] samples_per_unit;
    logic [TimeBits-1:0]  short_limit;
    logic [TimeBits-1:0]  click_window_time;
    logic [TimeBits-1:0]  long_limit;
    logic [TimeBits-1:0]  max_hold;
  } cfg_t;

endpackage

@@ sv/button_click_gesture_classifier.sv @@
// Top level of the button click gesture classifier.
//
// The input stream carries one button pin sample per beat in s_tdata bit 0,
// where 0 means pressed. A press counts once the pin reads low on two
// consecutive beats. The output stream carries one beat per finished
// gesture: gesture code and the number of debounced presses.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so only while the block is idle, which is not
// enforced. Indexes above four are ignored. Every input beat is classified
// in the cycle it is accepted, and its result, if any, is on the output in
// the next cycle. One beat is accepted every cycle unless a result stalls:
// the result register is the only stage, and s_tready stays high while it
// is empty or being drained in the same cycle. When the receiver stalls
// with a result waiting, s_tready drops until that beat is taken. Reset
// empties the result register, returns the classifier to idle with its
// timer and press count cleared, and restores the register defaults.
module button_click_gesture_classifier #(
  parameter int DURATION_BITS = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [0] button_level, [7:1] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [2:0] gesture, [5:3] click_count, [7:6] zero
  input  logic       cfg_we,
  input  logic [bccg_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [bccg_pkg::CfgDataBits-1:0] cfg_data
);

  bccg_pkg::cfg_t                 cfg;
  bccg_pkg::mode_t                mode;
  bccg_pkg::mode_t                mode_next;
  logic [bccg_pkg::PrescBits-1:0] presc;
  logic [bccg_pkg::PrescBits-1:0] presc_next;
  logic [DURATION_BITS-1:0]       dur;
  logic [DURATION_BITS-1:0]       dur_next;
  logic [bccg_pkg::CountBits-1:0] cnt;
  logic [bccg_pkg::CountBits-1:0] cnt_next;
  bccg_pkg::result_t              res;
  logic                           s_fire;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_unit <= bccg_pkg::PrescBits'(10);
      cfg.short_limit <= bccg_pkg::TimeBits'(3);
      cfg.click_window_time <= bccg_pkg::TimeBits'(8);
      cfg.long_limit <= bccg_pkg::TimeBits'(10);
      cfg.max_hold <= bccg_pkg::TimeBits'(50);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bccg_pkg::CFG_SAMPLES_PER_UNIT:
          cfg.samples_per_unit <= cfg_data[bccg_pkg::PrescBits-1:0];
        bccg_pkg::CFG_SHORT_LIMIT:       cfg.short_limit <= cfg_data;
        bccg_pkg::CFG_CLICK_WINDOW_TIME: cfg.click_window_time <= cfg_data;
        bccg_pkg::CFG_LONG_LIMIT:        cfg.long_limit <= cfg_data;
        bccg_pkg::CFG_MAX_HOLD:          cfg.max_hold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bccg_pkg::MODE_IDLE;
      presc <= '0;
      dur <= '0;
      cnt <= '0;
    end else if (s_fire) begin
      mode <= mode_next;
      presc <= presc_next;
      dur <= dur_next;
      cnt <= cnt_next;
    end
  end

  bccg_step #(
    .DURATION_BITS(DURATION_BITS)
  ) u_step (
    .cfg        (cfg),
    .mode       (mode),
    .presc      (presc),
    .dur        (dur),
    .cnt        (cnt),
    .low        (!s_tdata[0]),
    .mode_next  (mode_next),
    .presc_next (presc_next),
    .dur_next   (dur_next),
    .cnt_next   (cnt_next),
    .res        (res)
  );

  bccg_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (s_fire),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

@@ sv/bccg_step.sv @@
// Next-state and result logic for one button sample.
module bccg_step #(
  parameter int DURATION_BITS = 10
) (
  input  bccg_pkg::cfg_t                        cfg,
  input  bccg_pkg::mode_t                       mode,
  input  logic [bccg_pkg::PrescBits-1:0]        presc,
  input  logic [DURATION_BITS-1:0]              dur,
  input  logic [bccg_pkg::CountBits-1:0]        cnt,
  input  logic                                  low,
  output bccg_pkg::mode_t                       mode_next,
  output logic [bccg_pkg::PrescBits-1:0]        presc_next,
  output logic [DURATION_BITS-1:0]              dur_next,
  output logic [bccg_pkg::CountBits-1:0]        cnt_next,
  output bccg_pkg::result_t                     res
);

  localparam int CW = (DURATION_BITS > bccg_pkg::TimeBits) ? DURATION_BITS : bccg_pkg::TimeBits;
  localparam logic [DURATION_BITS-1:0] DurMax = {DURATION_BITS{1'b1}};
  localparam logic [bccg_pkg::CountBits-1:0] CntMax = {bccg_pkg::CountBits{1'b1}};

  logic [bccg_pkg::PrescBits-1:0] presc_inc;
  logic [bccg_pkg::PrescBits-1:0] presc_tick;
  logic [DURATION_BITS-1:0]       dur_tick;
  logic [CW-1:0]                  dur_ext;
  logic                           unit_done;
  logic                           closed;
  bccg_pkg::gesture_t             win_gesture;

  always_comb begin
    presc_inc = presc + bccg_pkg::PrescBits'(1);
    unit_done = presc_inc >= cfg.samples_per_unit;
    presc_tick = unit_done ? '0 : presc_inc;
    dur_tick = (unit_done && dur != DurMax) ? dur + DURATION_BITS'(1) : dur;
    dur_ext = CW'(dur_tick);
    closed = dur_ext >= CW'(cfg.click_window_time);
    if (cnt == bccg_pkg::CountBits'(2)) begin
      win_gesture = bccg_pkg::G_DOUBLE;
    end else if (cnt == bccg_pkg::CountBits'(3)) begin
      win_gesture = bccg_pkg::G_TRIPLE;
    end else begin
      win_gesture = bccg_pkg::G_UNKNOWN;
    end

    mode_next = mode;
    presc_next = presc;
    dur_next = dur;
    cnt_next = cnt;
    res.emit = 1'b0;
    res.gesture = bccg_pkg::G_UNKNOWN;
    res.click_count = cnt;

    unique case (mode)
      bccg_pkg::MODE_ARM: begin
        if (low) begin
          mode_next = bccg_pkg::MODE_HELD;
          cnt_next = bccg_pkg::CountBits'(1);
          presc_next = '0;
          dur_next = '0;
        end else begin
          mode_next = bccg_pkg::MODE_IDLE;
        end
      end
      bccg_pkg::MODE_HELD: begin
        presc_next = presc_tick;
        dur_next = dur_tick;
        if (!low) begin
          res.click_count = bccg_pkg::CountBits'(1);
          if (dur_ext < CW'(cfg.short_limit)) begin
            res.click_count = cnt;
            if (closed) begin
              res.emit = 1'b1;
              res.gesture = win_gesture;
            end else begin
              mode_next = bccg_pkg::MODE_WINDOW;
            end
          end else if (dur_ext > CW'(cfg.max_hold)) begin
            res.emit = 1'b1;
            res.gesture = bccg_pkg::G_UNKNOWN;
          end else if (dur_ext > CW'(cfg.long_limit)) begin
            res.emit = 1'b1;
            res.gesture = bccg_pkg::G_LONG;
          end else begin
            res.emit = 1'b1;
            res.gesture = bccg_pkg::G_SINGLE;
          end
        end
      end
      bccg_pkg::MODE_WINDOW: begin
        presc_next = presc_tick;
        dur_next = dur_tick;
        if (closed) begin
          res.emit = 1'b1;
          res.gesture = win_gesture;
        end else if (low) begin
          mode_next = bccg_pkg::MODE_WIN_ARM;
        end
      end
      bccg_pkg::MODE_WIN_ARM: begin
        presc_next = presc_tick;
        dur_next = dur_tick;
        if (low) begin
          if (cnt != CntMax) begin
            cnt_next = cnt + bccg_pkg::CountBits'(1);
          end
          mode_next = bccg_pkg::MODE_WIN_HELD;
        end else if (closed) begin
          res.emit = 1'b1;
          res.gesture = win_gesture;
        end else begin
          mode_next = bccg_pkg::MODE_WINDOW;
        end
      end
      bccg_pkg::MODE_WIN_HELD: begin
        presc_next = presc_tick;
        dur_next = dur_tick;
        if (!low) begin
          if (closed) begin
            res.emit = 1'b1;
            res.gesture = win_gesture;
          end else begin
            mode_next = bccg_pkg::MODE_WINDOW;
          end
        end
      end
      default: begin
        mode_next = low ? bccg_pkg::MODE_ARM : bccg_pkg::MODE_IDLE;
        presc_next = '0;
        dur_next = '0;
        cnt_next = '0;
      end
    endcase

    if (res.emit) begin
      mode_next = bccg_pkg::MODE_IDLE;
      presc_next = '0;
      dur_next = '0;
      cnt_next = '0;
    end
  end

endmodule

@@ sv/bccg_out.sv @@
// Result register between the classifier logic and the output stream.
module bccg_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bccg_pkg::result_t res,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [7:0]        m_tdata
);

  logic [bccg_pkg::GestureBits-1:0] gesture;
  logic [bccg_pkg::CountBits-1:0]   click_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= res.emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      gesture <= res.gesture;
      click_count <= res.click_count;
    end
  end

  assign m_tdata = {2'b00, click_count, gesture};

endmodule

@@ sv/bccg_checker.sv @@
// Port-level checks for the button click gesture classifier, with its bind.
module bccg_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output beat present right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output beat changed.");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("Input accepted while a stalled result is waiting.");

  a_multi_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == bccg_pkg::G_DOUBLE || m_tdata[2:0] == bccg_pkg::G_TRIPLE)
      |-> m_tdata[5:3] == m_tdata[2:0])
    else $error("Double or triple click reported with a wrong press count.");

  a_first_press_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == bccg_pkg::G_SINGLE || m_tdata[2:0] == bccg_pkg::G_LONG)
      |-> m_tdata[5:3] == 3'd1 && m_tdata[7:6] == 2'b00)
    else $error("Single or long click reported with a wrong press count.");

endmodule

bind button_click_gesture_classifier bccg_checker u_bccg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
